[design/stl_pkg.sv]
// Shared types, constants and helper functions for the script token lexer.
// No dependencies; every other design file refers to this package by scoped names.
package stl_pkg;

   localparam int OffsetBits   = 24;
   localparam int LineBits     = 20;
   localparam int LengthBits   = 8;
   localparam int KeywordChars = 8;
   localparam int KindBits     = 6;
   localparam int KwCount      = 19;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);
   localparam int WordBits     = KeywordChars * 8;

   localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_FRAC, M_DOT, M_OP, M_LCOM, M_BCOM, M_BSTAR, M_STR
   } mode_type;

   typedef enum logic [KindBits-1:0] {
      K_EOF, K_ERROR, K_IDENT, K_INT, K_FLOAT, K_STRING,
      K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_LBRACK, K_RBRACK,
      K_COMMA, K_DOT, K_TILDE, K_COLON, K_SEMI, K_QUEST,
      K_DEC, K_SUB_EQ, K_MINUS, K_INC, K_ADD_EQ, K_PLUS,
      K_DIV_EQ, K_SLASH, K_MUL_EQ, K_STAR,
      K_AND_EQ, K_LAND, K_AMP, K_OR_EQ, K_LOR, K_PIPE,
      K_NE, K_BANG, K_EQ, K_ARROW, K_ASSIGN,
      K_GE, K_SHR, K_GT, K_LE, K_SHL, K_LT,
      KW_CLASS, KW_ELSE, KW_IF, KW_NULL, KW_RETURN, KW_SUPER, KW_STRING,
      KW_STRUCT, KW_THIS, KW_TRUE, KW_FALSE, KW_FOR, KW_FN, KW_U_INT8,
      KW_U_INT16, KW_U_INT32, KW_VAR, KW_VAL, KW_WHILE
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [OffsetBits-1:0]   offset;
      logic [LengthBits-1:0]   length;
      logic [LineBits-1:0]     line;
      logic                    last;
   } token_type;

   // Tokens produced by one request, in order; count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   typedef struct packed {
      mode_type              mode;
      logic [7:0]            held;
      logic [OffsetBits-1:0] tok_offset;
      logic [LengthBits-1:0] tok_len;
      logic [LineBits-1:0]   line_count;
      logic [OffsetBits-1:0] byte_pos;
      logic                  too_long;
   } lex_state_type;

   localparam logic [WordBits-1:0] KwText [KwCount] = '{
      WordBits'("class"), WordBits'("else"), WordBits'("if"), WordBits'("null"),
      WordBits'("return"), WordBits'("super"), WordBits'("string"),
      WordBits'("struct"), WordBits'("this"), WordBits'("true"),
      WordBits'("false"), WordBits'("for"), WordBits'("fn"),
      WordBits'("u_int8"), WordBits'("u_int16"), WordBits'("u_int32"),
      WordBits'("var"), WordBits'("val"), WordBits'("while")
   };
   localparam int KwLen [KwCount] = '{5, 4, 2, 4, 6, 5, 6, 6, 4, 4, 5, 3, 2, 6, 7, 7, 3, 3, 5};
   localparam kind_type KwCode [KwCount] = '{
      KW_CLASS, KW_ELSE, KW_IF, KW_NULL, KW_RETURN, KW_SUPER, KW_STRING,
      KW_STRUCT, KW_THIS, KW_TRUE, KW_FALSE, KW_FOR, KW_FN, KW_U_INT8,
      KW_U_INT16, KW_U_INT32, KW_VAR, KW_VAL, KW_WHILE
   };

   function automatic logic alpha_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Returns K_EOF when the pair is not a two-character operator.
   function automatic kind_type op_pair(input logic [7:0] a, input logic [7:0] b);
      kind_type k;
      k = K_EOF;
      case (a)
         "-": if (b == "-") k = K_DEC; else if (b == "=") k = K_SUB_EQ;
         "+": if (b == "+") k = K_INC; else if (b == "=") k = K_ADD_EQ;
         "/": if (b == "=") k = K_DIV_EQ;
         "*": if (b == "=") k = K_MUL_EQ;
         "&": if (b == "=") k = K_AND_EQ; else if (b == "&") k = K_LAND;
         "|": if (b == "=") k = K_OR_EQ; else if (b == "|") k = K_LOR;
         "!": if (b == "=") k = K_NE;
         "=": if (b == "=") k = K_EQ; else if (b == ">") k = K_ARROW;
         ">": if (b == "=") k = K_GE; else if (b == ">") k = K_SHR;
         "<": if (b == "=") k = K_LE; else if (b == "<") k = K_SHL;
         default: k = K_EOF;
      endcase
      return k;
   endfunction

   function automatic kind_type op_single(input logic [7:0] a);
      kind_type k;
      case (a)
         "-":     k = K_MINUS;
         "+":     k = K_PLUS;
         "/":     k = K_SLASH;
         "*":     k = K_STAR;
         "&":     k = K_AMP;
         "|":     k = K_PIPE;
         "!":     k = K_BANG;
         "=":     k = K_ASSIGN;
         ">":     k = K_GT;
         default: k = K_LT;
      endcase
      return k;
   endfunction

   // Only the first len bytes of the word buffer are looked at.
   function automatic kind_type word_kind(input logic [WordBits-1:0] wb,
                                          input logic [LengthBits-1:0] len,
                                          input logic too_long);
      logic [WordBits-1:0] w;
      kind_type k;
      w = '0;
      k = K_IDENT;
      for (int j = 0; j < KeywordChars; j++) begin
         if (LengthBits'(j) < len) w = {w[WordBits-9:0], wb[8*j +: 8]};
      end
      if (!too_long && len <= LengthBits'(KeywordChars)) begin
         for (int i = 0; i < KwCount; i++) begin
            if (len == LengthBits'(KwLen[i]) && w == KwText[i]) k = KwCode[i];
         end
      end
      return k;
   endfunction

   function automatic token_type make_tok(input kind_type kind,
                                          input logic [OffsetBits-1:0] off,
                                          input logic [LengthBits-1:0] len,
                                          input logic [LineBits-1:0] line);
      token_type t;
      t.kind   = kind;
      t.offset = off;
      t.length = len;
      t.line   = line;
      t.last   = 1'b0;
      return t;
   endfunction

endpackage

[design/stl_engine.sv]
// Lexer engine: scanner state registers, word buffer and the per-byte step logic.
// Depends on stl_pkg.
module stl_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        src_byte,
   input  logic              end_of_source,
   output stl_pkg::push_type push
);

   stl_pkg::lex_state_type st_ff, st_in;
   logic [7:0] word_buf_ff [stl_pkg::KeywordChars];
   logic [stl_pkg::WordBits-1:0] word_flat;
   logic wr_en;
   logic [$clog2(stl_pkg::KeywordChars)-1:0] wr_idx;
   logic start;
   logic [1:0] n;
   stl_pkg::token_type t0, t1, tk;
   stl_pkg::kind_type pk, sk;
   logic [7:0] c;

   always_comb begin
      for (int j = 0; j < stl_pkg::KeywordChars; j++) word_flat[8*j +: 8] = word_buf_ff[j];
   end

   always_comb begin
      c      = src_byte;
      st_in  = st_ff;
      n      = 2'd0;
      t0     = '0;
      t1     = '0;
      tk     = '0;
      wr_en  = 1'b0;
      wr_idx = '0;
      start  = 1'b0;
      pk     = stl_pkg::K_EOF;
      sk     = stl_pkg::K_EOF;
      if (end_of_source) begin
         unique case (st_ff.mode)
            stl_pkg::M_IDENT: pk = stl_pkg::word_kind(word_flat, st_ff.tok_len, st_ff.too_long);
            stl_pkg::M_INT:   pk = stl_pkg::K_INT;
            stl_pkg::M_FRAC:  pk = stl_pkg::K_FLOAT;
            stl_pkg::M_DOT:   pk = stl_pkg::K_DOT;
            stl_pkg::M_OP:    pk = stl_pkg::op_single(st_ff.held);
            stl_pkg::M_STR:   pk = stl_pkg::K_ERROR;
            default:          pk = stl_pkg::K_EOF;
         endcase
         if (pk != stl_pkg::K_EOF) begin
            t0 = stl_pkg::make_tok(pk, st_ff.tok_offset, st_ff.tok_len, st_ff.line_count);
            n  = 2'd1;
         end
         tk = stl_pkg::make_tok(stl_pkg::K_EOF, st_ff.byte_pos, '0, st_ff.line_count);
         if (n == 2'd0) t0 = tk; else t1 = tk;
         n = n + 2'd1;
         st_in.mode       = stl_pkg::M_IDLE;
         st_in.held       = '0;
         st_in.tok_offset = '0;
         st_in.tok_len    = '0;
         st_in.line_count = stl_pkg::LineBits'(1);
         st_in.byte_pos   = '0;
         st_in.too_long   = 1'b0;
      end else begin
         unique case (st_ff.mode)
            stl_pkg::M_IDENT: begin
               if (stl_pkg::alpha_char(c) || stl_pkg::digit_char(c)) begin
                  if (st_ff.tok_len < stl_pkg::LengthBits'(stl_pkg::KeywordChars) &&
                      st_ff.tok_len < stl_pkg::LenMax) begin
                     wr_en  = 1'b1;
                     wr_idx = st_ff.tok_len[$clog2(stl_pkg::KeywordChars)-1:0];
                  end else begin
                     st_in.too_long = 1'b1;
                  end
                  if (st_ff.tok_len < stl_pkg::LenMax) st_in.tok_len = st_ff.tok_len + 1'b1;
               end else begin
                  pk    = stl_pkg::word_kind(word_flat, st_ff.tok_len, st_ff.too_long);
                  start = 1'b1;
               end
            end
            stl_pkg::M_INT, stl_pkg::M_FRAC: begin
               if (stl_pkg::digit_char(c) || c == "f" ||
                   (c == "." && st_ff.mode == stl_pkg::M_INT)) begin
                  if (st_ff.tok_len < stl_pkg::LenMax) st_in.tok_len = st_ff.tok_len + 1'b1;
                  if (c == ".") st_in.mode = stl_pkg::M_FRAC;
                  if (c == "f") begin
                     t0 = stl_pkg::make_tok(stl_pkg::K_FLOAT, st_ff.tok_offset,
                                            st_in.tok_len, st_ff.line_count);
                     n  = 2'd1;
                     st_in.mode = stl_pkg::M_IDLE;
                  end
               end else begin
                  pk    = (st_ff.mode == stl_pkg::M_INT) ? stl_pkg::K_INT : stl_pkg::K_FLOAT;
                  start = 1'b1;
               end
            end
            stl_pkg::M_DOT: begin
               if (stl_pkg::digit_char(c)) begin
                  if (st_ff.tok_len < stl_pkg::LenMax) st_in.tok_len = st_ff.tok_len + 1'b1;
                  st_in.mode = stl_pkg::M_FRAC;
               end else begin
                  pk    = stl_pkg::K_DOT;
                  start = 1'b1;
               end
            end
            stl_pkg::M_OP: begin
               sk = stl_pkg::op_pair(st_ff.held, c);
               if (st_ff.held == "/" && c == "/") begin
                  st_in.mode = stl_pkg::M_LCOM;
               end else if (st_ff.held == "/" && c == "*") begin
                  st_in.mode = stl_pkg::M_BCOM;
               end else if (sk != stl_pkg::K_EOF) begin
                  if (st_ff.tok_len < stl_pkg::LenMax) st_in.tok_len = st_ff.tok_len + 1'b1;
                  t0 = stl_pkg::make_tok(sk, st_ff.tok_offset, st_in.tok_len, st_ff.line_count);
                  n  = 2'd1;
                  st_in.mode = stl_pkg::M_IDLE;
               end else begin
                  pk    = stl_pkg::op_single(st_ff.held);
                  start = 1'b1;
               end
            end
            stl_pkg::M_LCOM: begin
               if (c == "\n") begin
                  st_in.line_count = st_ff.line_count + 1'b1;
                  st_in.mode = stl_pkg::M_IDLE;
               end
            end
            stl_pkg::M_BCOM: begin
               if (c == "*") st_in.mode = stl_pkg::M_BSTAR;
               else if (c == "\n") st_in.line_count = st_ff.line_count + 1'b1;
            end
            stl_pkg::M_BSTAR: begin
               if (c == "/") begin
                  st_in.mode = stl_pkg::M_IDLE;
               end else if (c == "\n") begin
                  st_in.line_count = st_ff.line_count + 1'b1;
                  st_in.mode = stl_pkg::M_BCOM;
               end else if (c != "*") begin
                  st_in.mode = stl_pkg::M_BCOM;
               end
            end
            stl_pkg::M_STR: begin
               if (st_ff.tok_len < stl_pkg::LenMax) st_in.tok_len = st_ff.tok_len + 1'b1;
               if (c == "\n") st_in.line_count = st_ff.line_count + 1'b1;
               if (c == 8'h22) begin
                  t0 = stl_pkg::make_tok(stl_pkg::K_STRING, st_ff.tok_offset,
                                         st_in.tok_len, st_in.line_count);
                  n  = 2'd1;
                  st_in.mode = stl_pkg::M_IDLE;
               end
            end
            default: start = 1'b1;
         endcase

         // A token ended by this byte goes out first; the byte then starts afresh.
         if (start) begin
            if (pk != stl_pkg::K_EOF) begin
               t0 = stl_pkg::make_tok(pk, st_ff.tok_offset, st_ff.tok_len, st_ff.line_count);
               n  = 2'd1;
            end
            st_in.mode       = stl_pkg::M_IDLE;
            st_in.tok_offset = st_ff.byte_pos;
            st_in.tok_len    = stl_pkg::LengthBits'(1);
            sk               = stl_pkg::K_EOF;
            case (c)
               " ", 8'h0D, "\t": st_in.tok_len = '0;
               "\n": begin
                  st_in.tok_len    = '0;
                  st_in.line_count = st_ff.line_count + 1'b1;
               end
               "(": sk = stl_pkg::K_LPAREN;
               ")": sk = stl_pkg::K_RPAREN;
               "{": sk = stl_pkg::K_LBRACE;
               "}": sk = stl_pkg::K_RBRACE;
               "[": sk = stl_pkg::K_LBRACK;
               "]": sk = stl_pkg::K_RBRACK;
               ",": sk = stl_pkg::K_COMMA;
               "~": sk = stl_pkg::K_TILDE;
               ":": sk = stl_pkg::K_COLON;
               ";": sk = stl_pkg::K_SEMI;
               "?": sk = stl_pkg::K_QUEST;
               ".": st_in.mode = stl_pkg::M_DOT;
               8'h22: st_in.mode = stl_pkg::M_STR;
               "-", "+", "/", "*", "&", "|", "!", "=", ">", "<": begin
                  st_in.held = c;
                  st_in.mode = stl_pkg::M_OP;
               end
               default: begin
                  if (stl_pkg::alpha_char(c)) begin
                     st_in.mode     = stl_pkg::M_IDENT;
                     st_in.too_long = 1'b0;
                     wr_en          = 1'b1;
                     wr_idx         = '0;
                  end else if (stl_pkg::digit_char(c)) begin
                     st_in.mode = stl_pkg::M_INT;
                  end else begin
                     sk = stl_pkg::K_ERROR;
                  end
               end
            endcase
            if (sk != stl_pkg::K_EOF) begin
               tk = stl_pkg::make_tok(sk, st_ff.byte_pos, stl_pkg::LengthBits'(1),
                                      st_in.line_count);
               if (n == 2'd0) t0 = tk; else t1 = tk;
               n = n + 2'd1;
            end
         end
         st_in.byte_pos = st_ff.byte_pos + 1'b1;
      end
      if (n == 2'd2) t1.last = 1'b1;
      else t0.last = 1'b1;
      push.count = accept ? n : 2'd0;
      push.tok0  = t0;
      push.tok1  = t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode       <= stl_pkg::M_IDLE;
         st_ff.held       <= '0;
         st_ff.tok_offset <= '0;
         st_ff.tok_len    <= '0;
         st_ff.line_count <= stl_pkg::LineBits'(1);
         st_ff.byte_pos   <= '0;
         st_ff.too_long   <= 1'b0;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !end_of_source && wr_en) word_buf_ff[wr_idx] <= c;
   end

   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      accept && !end_of_source && st_ff.mode == stl_pkg::M_STR && st_ff.tok_len == stl_pkg::LenMax
      |=> st_ff.tok_len == stl_pkg::LenMax)
      else $error("string length did not saturate");

   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_source
      |=> st_ff.byte_pos == '0 && st_ff.mode == stl_pkg::M_IDLE)
      else $error("end of source did not restart the scanner");

   a_eos_emits: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_source |-> push.count != 2'd0)
      else $error("end of source produced no token");

endmodule

[design/stl_queue.sv]
// Token queue: takes up to two tokens per cycle and hands out one per cycle while out_ready is high.
// Depends on stl_pkg.
module stl_queue (
   input  logic               clock,
   input  logic               reset,
   input  stl_pkg::push_type  push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output stl_pkg::token_type out_tok
);

   stl_pkg::token_type slot_ff [stl_pkg::QueueDepth];
   logic [stl_pkg::QueuePtrBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [stl_pkg::QueueCntBits-1:0] cnt_ff, cnt_in;
   logic pop;

   assign out_valid = cnt_ff != '0;
   assign out_tok   = slot_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // Room for the worst case of two tokens from one request.
   assign room      = cnt_ff <= stl_pkg::QueueCntBits'(stl_pkg::QueueDepth - 2);

   always_comb begin
      wr_in  = wr_ff + stl_pkg::QueuePtrBits'(push.count);
      rd_in  = rd_ff + stl_pkg::QueuePtrBits'(pop);
      cnt_in = cnt_ff + stl_pkg::QueueCntBits'(push.count) - stl_pkg::QueueCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) slot_ff[wr_ff] <= push.tok0;
      if (push.count == 2'd2) slot_ff[wr_ff + 1'b1] <= push.tok1;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= stl_pkg::QueueCntBits'(stl_pkg::QueueDepth))
      else $error("token queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("tokens pushed without room");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == stl_pkg::QueueCntBits'(stl_pkg::QueueDepth) || cnt_ff == '0 ||
      wr_ff != rd_ff)
      else $error("queue pointers disagree with fill count");

endmodule

[design/script_token_lexer_core.sv]
// Script token lexer, top level: scanner engine feeding a four-entry token queue.
// Depends on stl_pkg, stl_engine and stl_queue.
//
// One request carries a source byte or an end-of-source marker; the scanner
// state updates in the same cycle that the request is taken, so requests
// stream back to back at one per clock while req_ready is high. Each request
// yields zero, one or two tokens, which wait in a four-entry queue and leave
// one per clock on the rsp channel while rsp_ready is high; req_ready drops
// only while fewer than two queue entries are free, so the request rate drops
// below one per cycle only when tokens are made faster than they are taken.
module script_token_lexer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_src_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [23:0] rsp_token_offset,
   output logic [7:0]  rsp_token_length,
   output logic [19:0] rsp_token_line,
   output logic        rsp_last_of_run
);

   stl_pkg::push_type  push;
   stl_pkg::token_type head;
   logic accept;

   assign accept = req_valid && req_ready;

   stl_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .src_byte      (req_src_byte),
      .end_of_source (req_end_of_source),
      .push          (push)
   );

   stl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_tok   (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_offset = head.offset;
   assign rsp_token_length = head.length;
   assign rsp_token_line   = head.line;
   assign rsp_last_of_run  = head.last;

endmodule
